[sv/atte_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
package atte_pkg;
  typedef enum logic [1:0] {
    PM_NORMAL = 2'd0,
    PM_ESCAPE = 2'd1,
    PM_CSI    = 2'd2
  } parse_mode_t;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_DECODE,
    ST_READ_WAIT,
    ST_READ_DONE,
    ST_FILL,
    ST_SCROLL_RD,
    ST_SCROLL_WR,
    ST_PUT,
    ST_RESULT
  } state_t;

  localparam logic [7:0] BYTE_ESC    = 8'd27;
  localparam logic [7:0] BYTE_LBRACK = 8'h5B;
  localparam logic [7:0] BYTE_CR     = 8'h0D;
  localparam logic [7:0] BYTE_LF     = 8'h0A;
  localparam logic [7:0] BYTE_BS     = 8'h08;
  localparam logic [7:0] BYTE_TAB    = 8'h09;
  localparam logic [7:0] BYTE_SEMI   = 8'h3B;
  localparam logic [7:0] BYTE_QUERY  = 8'h3F;
  localparam logic [7:0] ATTR_RESET  = 8'h07;
  localparam logic [7:0] CHAR_SPACE  = 8'h20;
  localparam logic [15:0] ARG_MAX    = 16'hFFFF;
  localparam logic       KIND_HOST   = 1'b0;
  localparam logic       KIND_READ   = 1'b1;
  localparam logic [0:0] REG_COLS    = 1'b0;
  localparam logic [0:0] REG_ROWS    = 1'b1;
endpackage
`default_nettype wire

[sv/atte_if.sv]
`timescale 1ns / 1ps
`default_nettype none
interface atte_in_if;
  logic       valid;
  logic       ready;
  logic       kind;
  logic [7:0] host_byte;
  logic [5:0] read_row;
  logic [6:0] read_col;
  modport source (output valid, kind, host_byte, read_row, read_col, input ready);
  modport sink (input valid, kind, host_byte, read_row, read_col, output ready);
endinterface

interface atte_out_if;
  logic        valid;
  logic        ready;
  logic [7:0]  cursor_col;
  logic [6:0]  cursor_row;
  logic [7:0]  attribute;
  logic [15:0] cell_value;
  modport source (output valid, cursor_col, cursor_row, attribute, cell_value, input ready);
  modport sink (input valid, cursor_col, cursor_row, attribute, cell_value, output ready);
endinterface
`default_nettype wire

[sv/atte_ram.sv]
`timescale 1ns / 1ps
`default_nettype none
module atte_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 8192
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

[sv/ansi_text_terminal_engine.sv]
`timescale 1ns / 1ps
`default_nettype none
// Sequence: a read word passes DECODE, READ_WAIT, READ_DONE and RESULT;
//   cursor, mode and colour words pass DECODE and RESULT; a printable byte DECODE, PUT, RESULT (one cell write).
// Throughput: one word at a time. Erases write the cells one after another, a scroll
//   reads and then writes each cell of the area in use (port-limited single screen RAM).
// Reset: after rst all MAX_ROWS*MAX_COLS cells of the screen RAM are swept to zero,
//   one cell a cycle, while no word is taken; configuration is live.
module ansi_text_terminal_engine #(
  parameter int MAX_COLS = 128,
  parameter int MAX_ROWS = 64,
  parameter int MAX_ARGS = 16
) (
  input  wire logic        clk,
  input  wire logic        rst,
  atte_in_if.sink          in_ch,
  atte_out_if.source       out_ch,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:2]  paddr,
  input  wire logic [31:0] pwdata,
  output logic      [31:0] prdata,
  output logic             pready
);
  import atte_pkg::*;

  localparam int CW = $clog2(MAX_COLS);
  localparam int RW = $clog2(MAX_ROWS);
  localparam int AW = CW + RW;
  localparam int IW = $clog2(MAX_ARGS);
  localparam int DEPTH = MAX_ROWS * MAX_COLS;

  // Registers: cols/rows in use, cursor, parser
  logic [7:0] cols;
  logic [6:0] rows;
  logic [7:0] cur_col, cur_col_next;
  logic [6:0] cur_row, cur_row_next;
  logic [7:0] attr, attr_next;
  parse_mode_t parse_mode, parse_mode_next;
  logic [15:0] csi_args [MAX_ARGS];
  logic [IW-1:0] arg_index, arg_index_next;
  logic [7:0] saved_col, saved_col_next;
  logic [6:0] saved_row, saved_row_next;

  state_t state, state_next;

  // Held input word
  logic       h_kind;
  logic [7:0] h_byte;
  logic [5:0] h_rrow;
  logic [6:0] h_rcol;

  // Sweep counters (fill and scroll)
  logic [7:0] sw_col, sw_col_next;
  logic [6:0] sw_row, sw_row_next;
  logic [7:0] sw_end, sw_end_next;     // exclusive column limit on last row
  logic [6:0] sw_last, sw_last_next;   // last row of fill
  logic [7:0] sw_from, sw_from_next;   // start column on first row
  logic       after_put, after_put_next;

  // Output holding register
  logic        o_valid;
  logic [15:0] o_cell, o_cell_next;
  logic        load_out;

  // RAM
  logic          we;
  logic [AW-1:0] waddr, raddr;
  logic [15:0]   wdata, rdata;
  logic [AW:0]   clr_cnt;

  atte_ram #(.WIDTH(16), .DEPTH(DEPTH)) u_screen (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata)
  );

  function automatic logic [7:0] clip_cols(input logic [7:0] v);
    if (v < 8'd1) return 8'd1;
    if (32'(v) > MAX_COLS) return 8'(MAX_COLS);
    return v;
  endfunction
  function automatic logic [6:0] clip_rows(input logic [6:0] v);
    if (v < 7'd1) return 7'd1;
    if (32'(v) > MAX_ROWS) return 7'(MAX_ROWS);
    return v;
  endfunction

  // Configuration writes; repair the cursor with the new size
  logic cfg_wr;
  logic [7:0] cols_w;
  logic [6:0] rows_w;
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;
  assign prdata = (paddr[2] == REG_ROWS) ? {25'd0, rows} : {24'd0, cols};
  always_comb begin
    cols_w = cols;
    rows_w = rows;
    if (cfg_wr && paddr[2] == REG_COLS) cols_w = clip_cols(pwdata[7:0]);
    if (cfg_wr && paddr[2] == REG_ROWS) rows_w = clip_rows(pwdata[6:0]);
  end

  // Cursor as repaired before the word
  logic [7:0] rc_col;
  logic [6:0] rc_row;
  assign rc_col = (cur_col > cols) ? cols : cur_col;
  assign rc_row = (cur_row > rows) ? rows : cur_row;

  // Argument values
  logic [15:0] a0, a1, p1, p2;
  assign a0 = csi_args[0];
  assign a1 = csi_args[1];
  assign p1 = (a0 == 16'd0) ? 16'd1 : a0;
  assign p2 = (a1 == 16'd0) ? 16'd1 : a1;

  // Digit accumulate with saturation
  logic [19:0] acc;
  assign acc = {4'd0, csi_args[arg_index]} * 20'd10 + 20'(h_byte - 8'h30);

  // SGR: walk the arguments in one pass (independent narrow tests)
  logic [7:0] sgr_attr;
  always_comb begin
    sgr_attr = attr;
    for (int i = 0; i < MAX_ARGS; i++) begin
      if (i <= 32'(arg_index)) begin
        if (csi_args[i] == 16'd0) sgr_attr = ATTR_RESET;
        else if (csi_args[i] >= 16'd30 && csi_args[i] <= 16'd37)
          sgr_attr = {sgr_attr[7:4], 4'(csi_args[i] - 16'd30)};
        else if (csi_args[i] >= 16'd40 && csi_args[i] <= 16'd47)
          sgr_attr = {4'(csi_args[i] - 16'd40), sgr_attr[3:0]};
      end
    end
  end

  logic args_clear, arg_acc;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
      clr_cnt <= '0;
      cols <= clip_cols(8'd80);
      rows <= clip_rows(7'd24);
      cur_col <= '0;
      cur_row <= '0;
      attr <= ATTR_RESET;
      parse_mode <= PM_NORMAL;
      arg_index <= '0;
      saved_col <= '0;
      saved_row <= '0;
      o_valid <= 1'b0;
      for (int i = 0; i < MAX_ARGS; i++) csi_args[i] <= '0;
    end else begin
      state <= state_next;
      if (state == ST_CLEAR) clr_cnt <= clr_cnt + 1'b1;
      cols <= cols_w;
      rows <= rows_w;
      if (cfg_wr) begin
        cur_col <= (cur_col > cols_w) ? cols_w : cur_col;
        cur_row <= (cur_row > rows_w) ? rows_w : cur_row;
      end else begin
        cur_col <= cur_col_next;
        cur_row <= cur_row_next;
      end
      attr <= attr_next;
      parse_mode <= parse_mode_next;
      arg_index <= arg_index_next;
      saved_col <= saved_col_next;
      saved_row <= saved_row_next;
      if (args_clear) begin
        for (int i = 0; i < MAX_ARGS; i++) csi_args[i] <= '0;
      end else if (arg_acc) begin
        csi_args[arg_index] <= (acc > 20'(ARG_MAX)) ? ARG_MAX : acc[15:0];
      end
      if (load_out) o_valid <= 1'b1;
      else if (out_ch.ready) o_valid <= 1'b0;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      h_kind <= in_ch.kind;
      h_byte <= in_ch.host_byte;
      h_rrow <= in_ch.read_row;
      h_rcol <= in_ch.read_col;
    end
    sw_col <= sw_col_next;
    sw_row <= sw_row_next;
    sw_end <= sw_end_next;
    sw_last <= sw_last_next;
    sw_from <= sw_from_next;
    after_put <= after_put_next;
    o_cell <= o_cell_next;
    if (load_out) begin
      out_ch.cursor_col <= cur_col_next;
      out_ch.cursor_row <= cur_row_next;
      out_ch.attribute <= attr_next;
      out_ch.cell_value <= o_cell_next;
    end
  end

  assign out_ch.valid = o_valid;
  // Take a word only when idle and no register write is under way
  assign in_ch.ready = (state == ST_IDLE) && !cfg_wr;

  // Cell address helper
  function automatic logic [AW-1:0] cell_addr(input logic [6:0] r, input logic [7:0] c);
    return {r[RW-1:0], c[CW-1:0]};
  endfunction

  logic [15:0] blank;
  assign blank = {attr, CHAR_SPACE};

  always_comb begin
    state_next = state;
    cur_col_next = cur_col;
    cur_row_next = cur_row;
    attr_next = attr;
    parse_mode_next = parse_mode;
    arg_index_next = arg_index;
    saved_col_next = saved_col;
    saved_row_next = saved_row;
    sw_col_next = sw_col;
    sw_row_next = sw_row;
    sw_end_next = sw_end;
    sw_last_next = sw_last;
    sw_from_next = sw_from;
    after_put_next = after_put;
    o_cell_next = o_cell;
    args_clear = 1'b0;
    arg_acc = 1'b0;
    load_out = 1'b0;
    we = 1'b0;
    waddr = clr_cnt[AW-1:0];
    wdata = '0;
    raddr = cell_addr(7'(h_rrow), 8'(h_rcol));

    case (state)
      ST_CLEAR: begin
        we = 1'b1;
        if (clr_cnt == (AW+1)'(DEPTH - 1) || clr_cnt[AW]) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_ch.valid && in_ch.ready) state_next = ST_DECODE;
      end
      ST_DECODE: begin
        cur_col_next = rc_col;
        cur_row_next = rc_row;
        o_cell_next = '0;
        state_next = ST_RESULT;
        if (h_kind == KIND_READ) begin
          state_next = ST_READ_WAIT;
        end else begin
          case (parse_mode)
            PM_ESCAPE: begin
              if (h_byte == BYTE_LBRACK) begin
                parse_mode_next = PM_CSI;
                arg_index_next = '0;
                args_clear = 1'b1;
              end else parse_mode_next = PM_NORMAL;
            end
            PM_CSI: begin
              if (h_byte inside {[8'h30:8'h39]}) begin
                arg_acc = 1'b1;
              end else if (h_byte == BYTE_SEMI) begin
                if (32'(arg_index) < MAX_ARGS - 1) arg_index_next = arg_index + 1'b1;
              end else if (h_byte != BYTE_QUERY) begin
                parse_mode_next = PM_NORMAL;
                case (h_byte)
                  "A": cur_row_next = (p1 >= 16'(rc_row)) ? 7'd0 : rc_row - p1[6:0];
                  "B": cur_row_next = (17'(rc_row) + 17'(p1) >= 17'(rows)) ?
                                      rows - 7'd1 : rc_row + p1[6:0];
                  "C": cur_col_next = (17'(rc_col) + 17'(p1) >= 17'(cols)) ?
                                      cols - 8'd1 : rc_col + p1[7:0];
                  "D": cur_col_next = (p1 >= 16'(rc_col)) ? 8'd0 : rc_col - p1[7:0];
                  "H", "f": begin
                    cur_row_next = (p1 - 16'd1 >= 16'(rows)) ? rows - 7'd1 : 7'(p1 - 16'd1);
                    cur_col_next = (p2 - 16'd1 >= 16'(cols)) ? cols - 8'd1 : 8'(p2 - 16'd1);
                  end
                  "J", "K": begin
                    // Set up a fill sweep: from (row,from) to (last,end)
                    after_put_next = 1'b0;
                    sw_end_next = cols;
                    sw_from_next = 8'd0;
                    sw_row_next = rc_row;
                    sw_last_next = rc_row;
                    if (a0 == 16'd0) begin
                      sw_from_next = rc_col;
                      if (h_byte == "J") sw_last_next = rows - 7'd1;
                    end else if (a0 == 16'd1) begin
                      sw_end_next = (9'(rc_col) + 9'd1 > 9'(cols)) ? cols : rc_col + 8'd1;
                      if (h_byte == "J") sw_row_next = 7'd0;
                    end else if (a0 == 16'd2) begin
                      if (h_byte == "J") begin
                        sw_row_next = 7'd0;
                        sw_last_next = rows - 7'd1;
                      end
                    end
                    sw_col_next = (sw_row_next == rc_row) ? sw_from_next : 8'd0;
                    if (a0 <= 16'd2 && rc_row < rows) state_next = ST_FILL;
                    else if (a0 <= 16'd2 && h_byte == "J" && a0 == 16'd1 && rows > 7'd0)
                      begin
                        // row beyond screen: rows 0..rows-1 cleared fully
                        sw_last_next = rows - 7'd1;
                        sw_end_next = cols;
                        state_next = ST_FILL;
                      end
                  end
                  "m": attr_next = sgr_attr;
                  "s": begin
                    saved_col_next = rc_col;
                    saved_row_next = rc_row;
                  end
                  "u": begin
                    cur_col_next = (saved_col > cols) ? cols : saved_col;
                    cur_row_next = (saved_row > rows) ? rows : saved_row;
                  end
                  default: ;
                endcase
              end
            end
            default: begin
              parse_mode_next = PM_NORMAL;
              if (h_byte == BYTE_ESC) parse_mode_next = PM_ESCAPE;
              else if (h_byte == BYTE_CR) cur_col_next = 8'd0;
              else if (h_byte == BYTE_LF) begin
                if (rc_row < rows) cur_row_next = rc_row + 7'd1;
              end else if (h_byte == BYTE_BS) begin
                if (rc_col > 8'd0) cur_col_next = rc_col - 8'd1;
              end else if (h_byte == BYTE_TAB) begin
                cur_col_next = (9'({1'b0, rc_col} + 9'd8) & ~9'd7) > 9'(cols) ? cols
                             : 8'((9'(rc_col) + 9'd8) & ~9'd7);
              end else if (h_byte inside {[8'h20:8'h7E]}) begin
                if (rc_col >= cols) begin
                  cur_col_next = 8'd0;
                  if (rc_row < rows) cur_row_next = rc_row + 7'd1;
                end
                state_next = ST_PUT;
                if (((rc_col >= cols) ? ((rc_row < rows) ? rc_row + 7'd1 : rc_row)
                                      : rc_row) >= rows) begin
                  // Scroll: copy row r to r-1, then blank the bottom row
                  sw_row_next = 7'd1;
                  sw_col_next = 8'd0;
                  sw_end_next = cols;
                  sw_last_next = rows - 7'd1;
                  sw_from_next = 8'd0;
                  after_put_next = 1'b1;
                  cur_row_next = rows - 7'd1;
                  state_next = (rows > 7'd1) ? ST_SCROLL_RD : ST_FILL;
                  if (rows == 7'd1) sw_row_next = 7'd0;
                end
              end
            end
          endcase
        end
      end
      ST_READ_WAIT: state_next = ST_READ_DONE;
      ST_READ_DONE: begin
        o_cell_next = (7'(h_rrow) < rows && 8'(h_rcol) < cols) ? rdata : 16'd0;
        state_next = ST_RESULT;
      end
      ST_FILL: begin
        we = (sw_col < ((sw_row == sw_last) ? sw_end : cols));
        waddr = cell_addr(sw_row, sw_col);
        wdata = blank;
        if (sw_col + 8'd1 >= ((sw_row == sw_last) ? sw_end : cols)) begin
          sw_col_next = 8'd0;
          sw_row_next = sw_row + 7'd1;
          if (sw_row >= sw_last) state_next = after_put ? ST_PUT : ST_RESULT;
        end else sw_col_next = sw_col + 8'd1;
      end
      ST_SCROLL_RD: begin
        raddr = cell_addr(sw_row, sw_col);
        state_next = ST_SCROLL_WR;
      end
      ST_SCROLL_WR: begin
        we = 1'b1;
        waddr = cell_addr(sw_row - 7'd1, sw_col);
        wdata = rdata;
        state_next = ST_SCROLL_RD;
        if (sw_col + 8'd1 >= cols) begin
          sw_col_next = 8'd0;
          sw_row_next = sw_row + 7'd1;
          if (sw_row + 7'd1 >= rows) begin
            sw_row_next = rows - 7'd1;
            state_next = ST_FILL;
          end
        end else sw_col_next = sw_col + 8'd1;
      end
      ST_PUT: begin
        we = 1'b1;
        waddr = cell_addr(cur_row, cur_col);
        wdata = {attr, h_byte};
        cur_col_next = cur_col + 8'd1;
        after_put_next = 1'b0;
        state_next = ST_RESULT;
      end
      ST_RESULT: begin
        if (!o_valid || out_ch.ready) begin
          load_out = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // A result is never loaded over an untaken one
  assert property (@(posedge clk) disable iff (rst)
    load_out |-> (!o_valid || out_ch.ready))
    else $error("result overwritten");
  // No word is taken during the reset sweep
  assert property (@(posedge clk) disable iff (rst)
    (state == ST_CLEAR) |-> !in_ch.ready)
    else $error("word taken during clear");
  // Fill sweeps stay inside the memory rows in use
  assert property (@(posedge clk) disable iff (rst)
    (state == ST_FILL && we) |-> (sw_row < rows))
    else $error("fill outside screen");
endmodule
`default_nettype wire

[tb/atte_tb_if.sv]
`timescale 1ns / 1ps
// The channel interfaces come with the RTL (sv/atte_if.sv); this file only
// supplies the APB-style port bundle used by the stimulus.
interface atte_apb_if;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:2]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;
endinterface

[tb/atte_checker.sv]
`timescale 1ns / 1ps
module atte_checker
  import atte_pkg::*;
#(
  parameter int MAX_COLS = 128,
  parameter int MAX_ROWS = 64,
  parameter int MAX_ARGS = 16
) (
  input  logic        clk,
  input  logic        rst,
  atte_in_if          in_ch,
  atte_out_if         out_ch,
  input  logic        cfg_we,
  input  logic [0:0]  cfg_reg,
  input  logic [31:0] cfg_data,
  output int          fail_count,
  output int          pending
);
  typedef struct packed {
    logic [7:0]  col;
    logic [6:0]  row;
    logic [7:0]  attr;
    logic [15:0] cval;
  } answer_t;

  logic [15:0] scr [MAX_ROWS*MAX_COLS];
  int unsigned width_n, height_n, ccol, crow, attr_q, scol, srow, argn;
  int unsigned args [MAX_ARGS];
  parse_mode_t pmode;
  answer_t answers_q [$];

  function automatic int unsigned clamp_cfg(int unsigned v, int unsigned hi);
    return v < 1 ? 1 : (v > hi ? hi : v);
  endfunction

  task automatic blank_span(int unsigned r, int unsigned a, int unsigned b);
    if (r >= height_n) return;
    if (b > width_n) b = width_n;
    for (int unsigned c = a; c < b; c++) scr[r*MAX_COLS+c] = {attr_q[7:0], CHAR_SPACE};
  endtask

  task automatic repair();
    if (ccol > width_n) ccol = width_n;
    if (crow > height_n) crow = height_n;
  endtask

  task automatic do_final(logic [7:0] b);
    int unsigned p1, p2;
    p1 = args[0] == 0 ? 1 : args[0];
    p2 = args[1] == 0 ? 1 : args[1];
    case (b)
      "A": crow = p1 >= crow ? 0 : crow - p1;
      "B": crow = crow + p1 >= height_n ? height_n - 1 : crow + p1;
      "C": ccol = ccol + p1 >= width_n ? width_n - 1 : ccol + p1;
      "D": ccol = p1 >= ccol ? 0 : ccol - p1;
      "H", "f": begin
        crow = p1 - 1 >= height_n ? height_n - 1 : p1 - 1;
        ccol = p2 - 1 >= width_n ? width_n - 1 : p2 - 1;
      end
      "J": begin
        if (args[0] == 0) begin
          blank_span(crow, ccol, width_n);
          for (int unsigned r = crow + 1; r < height_n; r++) blank_span(r, 0, width_n);
        end else if (args[0] == 1) begin
          for (int unsigned r = 0; r < crow && r < height_n; r++) blank_span(r, 0, width_n);
          blank_span(crow, 0, ccol + 1);
        end else if (args[0] == 2) begin
          for (int unsigned r = 0; r < height_n; r++) blank_span(r, 0, width_n);
        end
      end
      "K": begin
        if (args[0] == 0) blank_span(crow, ccol, width_n);
        else if (args[0] == 1) blank_span(crow, 0, ccol + 1);
        else if (args[0] == 2) blank_span(crow, 0, width_n);
      end
      "m": begin
        for (int unsigned i = 0; i <= argn && i < MAX_ARGS; i++) begin
          if (args[i] == 0) attr_q = ATTR_RESET;
          else if (args[i] >= 30 && args[i] <= 37) attr_q = (attr_q & 'hF0) | (args[i] - 30);
          else if (args[i] >= 40 && args[i] <= 47)
            attr_q = (attr_q & 'h0F) | ((args[i] - 40) << 4);
        end
      end
      "s": begin
        scol = ccol;
        srow = crow;
      end
      "u": begin
        ccol = scol;
        crow = srow;
        repair();
      end
      default: ;
    endcase
  endtask

  task automatic print_byte(logic [7:0] b);
    if (ccol >= width_n) begin
      ccol = 0;
      if (crow < height_n) crow++;
    end
    if (crow >= height_n) begin
      for (int unsigned r = 1; r < height_n; r++)
        for (int unsigned c = 0; c < width_n; c++)
          scr[(r-1)*MAX_COLS+c] = scr[r*MAX_COLS+c];
      blank_span(height_n - 1, 0, width_n);
      crow = height_n - 1;
    end
    scr[crow*MAX_COLS+ccol] = {attr_q[7:0], b};
    ccol++;
  endtask

  task automatic interpret(logic [7:0] b);
    int unsigned v;
    if (pmode == PM_ESCAPE) begin
      if (b == BYTE_LBRACK) begin
        pmode = PM_CSI;
        argn = 0;
        foreach (args[i]) args[i] = 0;
      end else pmode = PM_NORMAL;
    end else if (pmode == PM_CSI) begin
      if (b >= "0" && b <= "9") begin
        v = args[argn] * 10 + (b - "0");
        args[argn] = v > ARG_MAX ? ARG_MAX : v;
      end else if (b == BYTE_SEMI) begin
        if (argn < MAX_ARGS - 1) argn++;
      end else if (b != BYTE_QUERY) begin
        do_final(b);
        pmode = PM_NORMAL;
      end
    end else begin
      if (b == BYTE_ESC) pmode = PM_ESCAPE;
      else if (b == BYTE_CR) ccol = 0;
      else if (b == BYTE_LF) begin
        if (crow < height_n) crow++;
      end else if (b == BYTE_BS) begin
        if (ccol > 0) ccol--;
      end else if (b == BYTE_TAB) begin
        ccol = (ccol + 8) & ~32'd7;
        if (ccol > width_n) ccol = width_n;
      end else if (b >= 8'h20 && b <= 8'h7E) print_byte(b);
    end
  endtask

  assign pending = answers_q.size();

  always @(posedge clk) begin
    answer_t ans, got;
    if (rst) begin
      foreach (scr[i]) scr[i] = '0;
      width_n = 80; height_n = 24; ccol = 0; crow = 0; attr_q = ATTR_RESET;
      pmode = PM_NORMAL; argn = 0; scol = 0; srow = 0;
      foreach (args[i]) args[i] = 0;
      answers_q.delete();
      fail_count <= 0;
    end else begin
      if (cfg_we) begin
        if (cfg_reg == REG_COLS) width_n = clamp_cfg(cfg_data[7:0], MAX_COLS);
        else height_n = clamp_cfg(cfg_data[6:0], MAX_ROWS);
        repair();
      end
      if (in_ch.valid && in_ch.ready) begin
        ans.cval = '0;
        repair();
        if (in_ch.kind == KIND_HOST) interpret(in_ch.host_byte);
        else if (in_ch.read_row < height_n && in_ch.read_col < width_n)
          ans.cval = scr[in_ch.read_row*MAX_COLS+in_ch.read_col];
        ans.col = 8'(ccol); ans.row = 7'(crow); ans.attr = 8'(attr_q);
        answers_q.push_back(ans);
      end
      if (out_ch.valid && out_ch.ready) begin
        got = '{out_ch.cursor_col, out_ch.cursor_row, out_ch.attribute, out_ch.cell_value};
        if (answers_q.size() == 0) begin
          $error("unexpected word: cursor_col %0d", got.col);
          fail_count <= fail_count + 1;
        end else begin
          ans = answers_q.pop_front();
          if (got != ans) begin
            if (got.col != ans.col) $error("cursor_col exp %0d got %0d", ans.col, got.col);
            if (got.row != ans.row) $error("cursor_row exp %0d got %0d", ans.row, got.row);
            if (got.attr != ans.attr) $error("attribute exp %h got %h", ans.attr, got.attr);
            if (got.cval != ans.cval) $error("cell_value exp %h got %h", ans.cval, got.cval);
            fail_count <= fail_count + 1;
          end
        end
      end
    end
  end
endmodule

[tb/tb_ansi_text_terminal_engine.sv]
`timescale 1ns / 1ps
module tb_ansi_text_terminal_engine;
  import atte_pkg::*;

  logic clk, rst;
  atte_in_if  in_ch();
  atte_out_if out_ch();
  atte_apb_if apb();

  int fail_count, pending;
  longint cycles;
  bit cfg_we;
  logic [0:0]  cfg_reg;
  logic [31:0] cfg_data;

  ansi_text_terminal_engine dut (
    .clk(clk), .rst(rst), .in_ch(in_ch), .out_ch(out_ch),
    .psel(apb.psel), .penable(apb.penable), .pwrite(apb.pwrite),
    .paddr(apb.paddr), .pwdata(apb.pwdata), .prdata(apb.prdata), .pready(apb.pready)
  );

  // Mirror every completed register write into the checker.
  assign cfg_we   = apb.psel && apb.penable && apb.pwrite && apb.pready;
  assign cfg_reg  = apb.paddr;
  assign cfg_data = apb.pwdata;

  atte_checker chk (
    .clk(clk), .rst(rst), .in_ch(in_ch), .out_ch(out_ch),
    .cfg_we(cfg_we), .cfg_reg(cfg_reg), .cfg_data(cfg_data),
    .fail_count(fail_count), .pending(pending)
  );

  initial begin
    clk = 0;
    forever #2 clk = ~clk;
  end

  // Watchdog: the reset sweep and a full-screen scroll are long, so allow plenty.
  initial begin
    cycles = 0;
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles > 3000000) begin
        $display("Mismatches found");
        $finish;
      end
    end
  end

  // Receiver stall pattern: alternate stretches of free flow and random stalls.
  initial begin
    int phase;
    out_ch.ready = 0;
    phase = 0;
    forever begin
      @(posedge clk);
      phase++;
      if ((phase / 64) % 3 == 0) out_ch.ready <= 1'b1;
      else out_ch.ready <= ($urandom_range(0, 3) != 0);
    end
  end

  int burst_left;

  // Drive one word, then hold valid until it is taken. Bursts and gaps are random.
  task automatic send_word(bit k, logic [7:0] b, logic [5:0] r, logic [6:0] c);
    if (burst_left == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
      burst_left = $urandom_range(1, 12);
    end
    in_ch.valid <= 1'b1;
    in_ch.kind <= k;
    in_ch.host_byte <= b;
    in_ch.read_row <= r;
    in_ch.read_col <= c;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    burst_left--;
  endtask

  task automatic send_host(logic [7:0] b);
    send_word(KIND_HOST, b, 6'($urandom), 7'($urandom));
  endtask

  task automatic send_read(logic [5:0] r, logic [6:0] c);
    send_word(KIND_READ, 8'($urandom), r, c);
  endtask

  task automatic send_text(string s);
    for (int i = 0; i < s.len(); i++) send_host(s[i]);
  endtask

  // Drain, let the block finish any erase or scroll, then write a register.
  task automatic write_reg(logic [0:0] idx, logic [31:0] val);
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (20000) @(posedge clk);
    apb.psel <= 1'b1; apb.penable <= 1'b0; apb.pwrite <= 1'b1;
    apb.paddr <= idx; apb.pwdata <= val;
    @(posedge clk);
    apb.penable <= 1'b1;
    @(posedge clk);
    apb.psel <= 1'b0; apb.penable <= 1'b0; apb.pwrite <= 1'b0;
    @(posedge clk);
  endtask

  // Random escape sequence: mostly well formed, sometimes broken.
  task automatic send_sequence();
    byte finals [13] = '{"A", "B", "C", "D", "H", "f", "J", "K", "m", "s", "u", "x", "?"};
    int n;
    send_host(BYTE_ESC);
    if ($urandom_range(0, 9) == 0) begin
      send_host(8'($urandom));
      return;
    end
    send_host(BYTE_LBRACK);
    n = $urandom_range(0, 3);
    for (int i = 0; i < n; i++) begin
      if (i > 0) send_host(BYTE_SEMI);
      case ($urandom_range(0, 3))
        0: send_host(8'("0" + $urandom_range(0, 2)));
        1: send_text($sformatf("%0d", $urandom_range(30, 47)));
        2: send_text($sformatf("%0d", $urandom_range(1, 70)));
        default: send_text($sformatf("%0d", $urandom_range(0, 200000)));
      endcase
    end
    send_host(finals[$urandom_range(0, 12)]);
    if (finals[0] == "A" && $urandom_range(0, 1)) send_host(finals[$urandom_range(0, 10)]);
  endtask

  task automatic random_items(int count);
    for (int i = 0; i < count; i++) begin
      case ($urandom_range(0, 9))
        0, 1, 2: send_host(8'($urandom_range(8'h20, 8'h7E)));
        3: send_host(8'($urandom));
        4: send_host($urandom_range(0, 1) ? BYTE_LF : BYTE_CR);
        5: send_host($urandom_range(0, 1) ? BYTE_TAB : BYTE_BS);
        6, 7: send_sequence();
        default: send_read(6'($urandom), 7'($urandom));
      endcase
    end
  endtask

  initial begin
    rst = 1;
    burst_left = 0;
    in_ch.valid = 0; in_ch.kind = 0; in_ch.host_byte = 0;
    in_ch.read_row = 0; in_ch.read_col = 0;
    apb.psel = 0; apb.penable = 0; apb.pwrite = 0; apb.paddr = 0; apb.pwdata = 0;
    repeat (2) @(posedge clk);
    rst <= 0;

    // Directed: small screen, wrap, scroll, tabs, erases, colours, save/restore.
    write_reg(REG_COLS, 32'd10);
    write_reg(REG_ROWS, 32'd3);
    send_text("\x1b[31;44mAbcdefghijK~");
    send_host(BYTE_TAB); send_host(BYTE_BS); send_host(BYTE_LF); send_host(BYTE_LF);
    send_host(BYTE_LF); send_text("Z\r\x1b[s\x1b[99;99H\x1b[u\x1b[2;?5f\x1b[1K\x1b[0J");
    send_text("\x1b[99999999A\x1b[;;;;;;;;;;;;;;;;;;;2J\x1b[0m\x1bq\x1b[3J\x1b[z");
    send_host(8'hFF); send_host(8'h07); send_host(8'h7F);
    send_read(6'd0, 7'd0); send_read(6'd2, 7'd9); send_read(6'd63, 7'd127);

    write_reg(REG_COLS, 32'd0);
    write_reg(REG_ROWS, 32'd0);
    random_items(25);
    write_reg(REG_COLS, 32'd255);
    write_reg(REG_ROWS, 32'd127);
    random_items(45);
    write_reg(REG_COLS, 32'd7);
    write_reg(REG_ROWS, 32'd2);
    random_items(55);
    write_reg(REG_COLS, 32'd128);
    write_reg(REG_ROWS, 32'd64);
    random_items(30);

    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (fail_count == 0) $display("No mismatches found");
    else $display("Mismatches found");
    $finish;
  end
endmodule
